FILE: rtl/nlpf_pkg.sv
package nlpf_pkg;

    // section id width, fixed by the report format
    localparam int ID_W = 8;

    // default table size
    localparam int MAX_SECTIONS_DEF = 256;

    // configuration port
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 8;

    // stream payload widths, padded to whole bytes
    localparam int S_TDATA_W = 16;
    localparam int M_TDATA_W = 24;

    // configuration register indexes
    typedef enum logic [CFG_ADDR_W-1:0] {
        CFG_OWN_ID        = 3'd0,
        CFG_OWN_HEAD_HEAD = 3'd1,
        CFG_OWN_HEAD_TAIL = 3'd2,
        CFG_OWN_TAIL_HEAD = 3'd3,
        CFG_OWN_TAIL_TAIL = 3'd4
    } t_cfg_idx;

    // one table entry as stored in the ram
    typedef struct packed {
        logic tt;
        logic th;
        logic ht;
        logic hh;
        logic valid;
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);

    // controller states
    typedef enum logic [3:0] {
        ST_CLEAR  = 4'b0001,
        ST_IDLE   = 4'b0010,
        ST_SCAN   = 4'b0100,
        ST_FINISH = 4'b1000
    } t_state;

endpackage

FILE: rtl/nlpf_ram.sv
module nlpf_ram #(
    parameter int WIDTH = nlpf_pkg::ENTRY_W,
    parameter int DEPTH = nlpf_pkg::MAX_SECTIONS_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: rtl/nearest_link_partner_finder_unit.sv
// channel    direction  payload
// s_axis     in         tdata: sender_id[7:0] hh[8] ht[9] th[10] tt[11], pad to 16
// m_axis     out        tdata: head_partner[7:0] tail_partner[15:8] changed[16], pad to 24
// cfg        in         write only: own_id, own hh, own ht, own th, own tt
//
// a stored report is written to the ram, then the scan reads every table entry
// (DEPTH = min(MAX_SECTIONS, 256)) in turn, drains the read stage and posts the result
// own-id, zero-id and out-of-range reports are taken but give no result
// after reset a clearing pass walks every ram entry; no report is taken meanwhile
// a result waits in the output register; if it is still held when the next scan
// ends, the block stalls in its finish step until the register frees
module nearest_link_partner_finder_unit #(
    parameter int MAX_SECTIONS = nlpf_pkg::MAX_SECTIONS_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // report input
    input  logic                             i_s_axis_tvalid,
    output logic                             o_s_axis_tready,
    // sender_id[7:0], hh[8], ht[9], th[10], tt[11], zero pad
    input  logic [nlpf_pkg::S_TDATA_W-1:0]   i_s_axis_tdata,
    // result output
    output logic                             o_m_axis_tvalid,
    input  logic                             i_m_axis_tready,
    // head_partner[7:0], tail_partner[15:8], partner_changed[16], zero pad
    output logic [nlpf_pkg::M_TDATA_W-1:0]   o_m_axis_tdata,
    // configuration
    input  logic                             i_cfg_we,
    input  logic [nlpf_pkg::CFG_ADDR_W-1:0]  i_cfg_addr,
    input  logic [nlpf_pkg::CFG_DATA_W-1:0]  i_cfg_data
);

    localparam int ID_W  = nlpf_pkg::ID_W;
    localparam int DEPTH = (MAX_SECTIONS < (1 << ID_W)) ? MAX_SECTIONS : (1 << ID_W);
    localparam int AW    = $clog2(DEPTH);
    localparam logic [AW-1:0] LAST_ADDR = AW'(DEPTH - 1);

    // configuration registers
    logic [ID_W-1:0] r_own_id;
    logic            r_own_hh, r_own_ht, r_own_th, r_own_tt;

    // controller
    nlpf_pkg::t_state r_state, n_state;
    logic [AW-1:0]    r_addr, n_addr;
    logic             r_issue_done, n_issue_done;
    logic             r_eval_valid, n_eval_valid;
    logic             r_eval_last, n_eval_last;
    logic [AW-1:0]    r_eval_id, n_eval_id;

    // running best partners
    logic             r_head_found, n_head_found;
    logic [ID_W-1:0]  r_head_dist, n_head_dist;
    logic [ID_W-1:0]  r_head_id, n_head_id;
    logic             r_tail_found, n_tail_found;
    logic [ID_W-1:0]  r_tail_dist, n_tail_dist;
    logic [ID_W-1:0]  r_tail_id, n_tail_id;

    // current partners and output register
    logic [ID_W-1:0]  r_cur_head, n_cur_head;
    logic [ID_W-1:0]  r_cur_tail, n_cur_tail;
    logic             r_out_valid, n_out_valid;
    logic [ID_W-1:0]  r_out_head, n_out_head;
    logic [ID_W-1:0]  r_out_tail, n_out_tail;
    logic             r_out_chg, n_out_chg;

    // input decode
    logic [ID_W-1:0]  w_sid;
    logic             w_s_xfer;
    logic             w_store;
    nlpf_pkg::t_entry w_new_entry;

    // ram ports
    logic             w_ram_we;
    logic [AW-1:0]    w_ram_waddr;
    nlpf_pkg::t_entry w_ram_wdata;
    logic             w_ram_re;
    nlpf_pkg::t_entry w_rd_entry;

    // evaluation of one returned entry
    logic [ID_W-1:0]  w_eval_id;
    logic [ID_W-1:0]  w_dist;
    logic             w_head_take, w_tail_take;
    logic             w_out_free;

    assign w_sid    = i_s_axis_tdata[ID_W-1:0];
    assign w_s_xfer = i_s_axis_tvalid && o_s_axis_tready;
    assign w_store  = w_s_xfer && (w_sid != '0) && (w_sid != r_own_id) &&
                      (32'(w_sid) < 32'(MAX_SECTIONS));

    assign w_new_entry.valid = 1'b1;
    assign w_new_entry.hh    = i_s_axis_tdata[ID_W];
    assign w_new_entry.ht    = i_s_axis_tdata[ID_W+1];
    assign w_new_entry.th    = i_s_axis_tdata[ID_W+2];
    assign w_new_entry.tt    = i_s_axis_tdata[ID_W+3];

    // ram write: clearing pass or a stored report
    always_comb begin
        if (r_state == nlpf_pkg::ST_CLEAR) begin
            w_ram_we    = 1'b1;
            w_ram_waddr = r_addr;
            w_ram_wdata = '0;
        end else begin
            w_ram_we    = w_store;
            w_ram_waddr = w_sid[AW-1:0];
            w_ram_wdata = w_new_entry;
        end
    end

    assign w_ram_re = (r_state == nlpf_pkg::ST_SCAN) && !r_issue_done;

    nlpf_ram #(
        .WIDTH (nlpf_pkg::ENTRY_W),
        .DEPTH (DEPTH)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (w_ram_we),
        .i_waddr (w_ram_waddr),
        .i_wdata (w_ram_wdata),
        .i_re    (w_ram_re),
        .i_raddr (r_addr),
        .o_rdata (w_rd_entry)
    );

    // distance and candidate check for the entry read last cycle
    assign w_eval_id = ID_W'(r_eval_id);
    assign w_dist    = (r_own_id > w_eval_id) ? (r_own_id - w_eval_id)
                                              : (w_eval_id - r_own_id);

    assign w_head_take = w_rd_entry.valid &&
                         ((r_own_hh && w_rd_entry.hh) || (r_own_ht && w_rd_entry.th)) &&
                         (!r_head_found || (w_dist < r_head_dist));
    assign w_tail_take = w_rd_entry.valid &&
                         ((r_own_th && w_rd_entry.ht) || (r_own_tt && w_rd_entry.tt)) &&
                         (!r_tail_found || (w_dist < r_tail_dist));

    assign w_out_free = !r_out_valid || i_m_axis_tready;

    // next state
    always_comb begin
        n_state      = r_state;
        n_addr       = r_addr;
        n_issue_done = r_issue_done;
        n_eval_valid = 1'b0;
        n_eval_last  = r_eval_last;
        n_eval_id    = r_eval_id;
        n_head_found = r_head_found;
        n_head_dist  = r_head_dist;
        n_head_id    = r_head_id;
        n_tail_found = r_tail_found;
        n_tail_dist  = r_tail_dist;
        n_tail_id    = r_tail_id;
        n_cur_head   = r_cur_head;
        n_cur_tail   = r_cur_tail;
        n_out_valid  = r_out_valid && !i_m_axis_tready;
        n_out_head   = r_out_head;
        n_out_tail   = r_out_tail;
        n_out_chg    = r_out_chg;

        unique case (r_state)
            nlpf_pkg::ST_CLEAR: begin
                n_addr = r_addr + 1'b1;
                if (r_addr == LAST_ADDR) begin
                    n_state = nlpf_pkg::ST_IDLE;
                end
            end
            nlpf_pkg::ST_IDLE: begin
                if (w_store) begin
                    n_state      = nlpf_pkg::ST_SCAN;
                    n_addr       = '0;
                    n_issue_done = 1'b0;
                    n_head_found = 1'b0;
                    n_head_id    = '0;
                    n_tail_found = 1'b0;
                    n_tail_id    = '0;
                end
            end
            nlpf_pkg::ST_SCAN: begin
                // read issue, one entry per cycle in ascending id order
                if (!r_issue_done) begin
                    n_addr       = r_addr + 1'b1;
                    n_issue_done = (r_addr == LAST_ADDR);
                    n_eval_valid = 1'b1;
                    n_eval_id    = r_addr;
                    n_eval_last  = (r_addr == LAST_ADDR);
                end
                // compare stage, strict less keeps the lower id on a tie
                if (r_eval_valid) begin
                    if (w_head_take) begin
                        n_head_found = 1'b1;
                        n_head_dist  = w_dist;
                        n_head_id    = w_eval_id;
                    end
                    if (w_tail_take) begin
                        n_tail_found = 1'b1;
                        n_tail_dist  = w_dist;
                        n_tail_id    = w_eval_id;
                    end
                    if (r_eval_last) begin
                        n_state = nlpf_pkg::ST_FINISH;
                    end
                end
            end
            nlpf_pkg::ST_FINISH: begin
                if (w_out_free) begin
                    n_out_valid = 1'b1;
                    n_out_head  = r_head_id;
                    n_out_tail  = r_tail_id;
                    n_out_chg   = (r_head_id != r_cur_head) || (r_tail_id != r_cur_tail);
                    n_cur_head  = r_head_id;
                    n_cur_tail  = r_tail_id;
                    n_state     = nlpf_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = nlpf_pkg::ST_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= nlpf_pkg::ST_CLEAR;
            r_addr       <= '0;
            r_issue_done <= 1'b0;
            r_eval_valid <= 1'b0;
            r_eval_last  <= 1'b0;
            r_cur_head   <= '0;
            r_cur_tail   <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_addr       <= n_addr;
            r_issue_done <= n_issue_done;
            r_eval_valid <= n_eval_valid;
            r_eval_last  <= n_eval_last;
            r_cur_head   <= n_cur_head;
            r_cur_tail   <= n_cur_tail;
            r_out_valid  <= n_out_valid;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_eval_id    <= n_eval_id;
        r_head_found <= n_head_found;
        r_head_dist  <= n_head_dist;
        r_head_id    <= n_head_id;
        r_tail_found <= n_tail_found;
        r_tail_dist  <= n_tail_dist;
        r_tail_id    <= n_tail_id;
        r_out_head   <= n_out_head;
        r_out_tail   <= n_out_tail;
        r_out_chg    <= n_out_chg;
    end

    // configuration writes, indexes past the list are dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_own_id <= ID_W'(1);
            r_own_hh <= 1'b0;
            r_own_ht <= 1'b0;
            r_own_th <= 1'b0;
            r_own_tt <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                nlpf_pkg::CFG_OWN_ID:        r_own_id <= i_cfg_data[ID_W-1:0];
                nlpf_pkg::CFG_OWN_HEAD_HEAD: r_own_hh <= i_cfg_data[0];
                nlpf_pkg::CFG_OWN_HEAD_TAIL: r_own_ht <= i_cfg_data[0];
                nlpf_pkg::CFG_OWN_TAIL_HEAD: r_own_th <= i_cfg_data[0];
                nlpf_pkg::CFG_OWN_TAIL_TAIL: r_own_tt <= i_cfg_data[0];
                default: begin
                end
            endcase
        end
    end

    // ports
    assign o_s_axis_tready = (r_state == nlpf_pkg::ST_IDLE);
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {{(nlpf_pkg::M_TDATA_W - 2*ID_W - 1){1'b0}},
                              r_out_chg, r_out_tail, r_out_head};

endmodule

FILE: tb/sv/tb_nearest_link_partner_finder_unit.sv
`timescale 1ns / 1ps

module tb_nearest_link_partner_finder_unit;

    localparam int ID_W       = nlpf_pkg::ID_W;
    localparam int S_TDATA_W  = nlpf_pkg::S_TDATA_W;
    localparam int M_TDATA_W  = nlpf_pkg::M_TDATA_W;
    localparam int CFG_ADDR_W = nlpf_pkg::CFG_ADDR_W;
    localparam int CFG_DATA_W = nlpf_pkg::CFG_DATA_W;

    localparam int TABLE_DEPTH      = nlpf_pkg::MAX_SECTIONS_DEF;
    // write, a read of each entry, drain, post
    localparam int SCAN_CYCLES      = TABLE_DEPTH + 3;
    localparam int SETTLE_CYCLES    = SCAN_CYCLES + 16;
    localparam int NO_PARTNER_DIST  = 10000;
    localparam int LONG_HOLD_CYCLES = 3000;
    localparam int RANDOM_STORED    = 216;

    // flag vector order used for own links and table entries
    localparam int LNK_HH = 0;
    localparam int LNK_HT = 1;
    localparam int LNK_TH = 2;
    localparam int LNK_TT = 3;

    typedef struct packed {
        logic            tt;
        logic            th;
        logic            ht;
        logic            hh;
        logic [ID_W-1:0] sender_id;
    } t_report;

    typedef struct packed {
        logic            partner_changed;
        logic [ID_W-1:0] tail_partner;
        logic [ID_W-1:0] head_partner;
    } t_partners;

    localparam int REPORT_W   = $bits(t_report);
    localparam int PARTNERS_W = $bits(t_partners);

    logic                  i_clk   = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  s_valid = 1'b0;
    logic [S_TDATA_W-1:0]  s_data  = '0;
    logic                  m_ready = 1'b0;
    logic                  cfg_we  = 1'b0;
    logic [CFG_ADDR_W-1:0] cfg_addr = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;
    logic                  s_ready;
    logic                  m_valid;
    logic [M_TDATA_W-1:0]  m_data;

    // predictor copy of registers and table
    int              own_id_cfg = 1;
    logic [3:0]      own_links  = 4'b0000;
    bit              link_valid [TABLE_DEPTH];
    logic [3:0]      link_flags [TABLE_DEPTH];
    logic [ID_W-1:0] head_now   = '0;
    logic [ID_W-1:0] tail_now   = '0;

    t_report   report_q [$];
    t_partners partner_q [$];

    int burst_left = 0;
    int gap_left   = 0;
    int stall_left = 0;
    int stall_pct  = 0;
    int hold_left  = 0;
    int taken_cnt  = 0;
    int holds_done = 0;
    int cyc        = 0;

    int reports_taken   = 0;
    int reports_stored  = 0;
    int results_checked = 0;
    int mismatch_cnt    = 0;
    int settings_cnt    = 0;

    t_report   seen_report;
    t_partners due;
    t_partners want;
    t_partners got;

    nearest_link_partner_finder_unit u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_valid),
        .o_s_axis_tready (s_ready),
        .i_s_axis_tdata  (s_data),
        .o_m_axis_tvalid (m_valid),
        .i_m_axis_tready (m_ready),
        .o_m_axis_tdata  (m_data),
        .i_cfg_we        (cfg_we),
        .i_cfg_addr      (cfg_addr),
        .i_cfg_data      (cfg_data)
    );

    always #10 i_clk = ~i_clk;

    // store a report unless its id is zero or own, and rescan the table for the nearest partners
    function automatic bit predict_partners(input t_report rep, output t_partners res);
        int              head_dist;
        int              tail_dist;
        int              id_span;
        logic [ID_W-1:0] head_id;
        logic [ID_W-1:0] tail_id;
        logic [3:0]      f;
        res = '0;
        if (rep.sender_id == '0 || int'(rep.sender_id) == own_id_cfg)
            return 1'b0;
        link_valid[rep.sender_id] = 1'b1;
        link_flags[rep.sender_id] = {rep.tt, rep.th, rep.ht, rep.hh};
        head_dist = NO_PARTNER_DIST;
        tail_dist = NO_PARTNER_DIST;
        head_id   = '0;
        tail_id   = '0;
        for (int id = 0; id < TABLE_DEPTH; id++) begin
            if (link_valid[id]) begin
                f       = link_flags[id];
                id_span = (id > own_id_cfg) ? id - own_id_cfg : own_id_cfg - id;
                if (((own_links[LNK_HH] && f[LNK_HH]) || (own_links[LNK_HT] && f[LNK_TH]))
                        && id_span < head_dist) begin
                    head_dist = id_span;
                    head_id   = ID_W'(id);
                end
                if (((own_links[LNK_TH] && f[LNK_HT]) || (own_links[LNK_TT] && f[LNK_TT]))
                        && id_span < tail_dist) begin
                    tail_dist = id_span;
                    tail_id   = ID_W'(id);
                end
            end
        end
        res.head_partner    = head_id;
        res.tail_partner    = tail_id;
        res.partner_changed = (head_id != head_now) || (tail_id != tail_now);
        head_now = head_id;
        tail_now = tail_id;
        return 1'b1;
    endfunction

    function automatic logic [S_TDATA_W-1:0] pack_report(input t_report rep);
        logic [S_TDATA_W-1:0] word;
        word = '0;
        word[REPORT_W-1:0] = rep;
        return word;
    endfunction

    // mostly short gaps, now and then one that spans a whole scan
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 9);
        if (r < 3)
            return 0;
        if (r < 8)
            return $urandom_range(1, 20);
        return $urandom_range(21, 400);
    endfunction

    // report sender: bursts from the pending queue with gaps between them
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_valid    <= 1'b0;
            s_data     <= '0;
            burst_left <= 0;
            gap_left   <= 0;
        end else if (!s_valid || s_ready) begin
            if (s_valid)
                report_q.delete(0);
            if (gap_left != 0) begin
                s_valid  <= 1'b0;
                gap_left <= gap_left - 1;
            end else if (report_q.size() == 0) begin
                s_valid <= 1'b0;
            end else begin
                s_valid <= 1'b1;
                s_data  <= pack_report(report_q[0]);
                if (burst_left > 1) begin
                    burst_left <= burst_left - 1;
                end else begin
                    burst_left <= $urandom_range(1, 12);
                    gap_left   <= pick_gap();
                end
            end
        end
    end

    // result receiver: random stalls whose rate is re-picked at random, rare long hold-off
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_ready    <= 1'b0;
            stall_left <= 0;
            stall_pct  <= 0;
            hold_left  <= 0;
            taken_cnt  <= 0;
            cyc        <= 0;
        end else begin
            cyc <= cyc + 1;
            if (cyc % 1024 == 0) begin
                case ($urandom_range(0, 2))
                    0:       stall_pct <= 0;
                    1:       stall_pct <= 2;
                    default: stall_pct <= 8;
                endcase
            end
            if (m_valid && m_ready)
                taken_cnt <= taken_cnt + 1;
            if (m_valid && m_ready && taken_cnt % 500 == 250) begin
                hold_left  <= LONG_HOLD_CYCLES;
                holds_done <= holds_done + 1;
                m_ready    <= 1'b0;
            end else if (hold_left != 0) begin
                hold_left <= hold_left - 1;
                m_ready   <= 1'b0;
            end else if (stall_left != 0) begin
                stall_left <= stall_left - 1;
                m_ready    <= 1'b0;
            end else if ($urandom_range(0, 99) < stall_pct) begin
                stall_left <= $urandom_range(0, 300);
                m_ready    <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    // input transfers feed the predictor
    always @(posedge i_clk) begin
        if (i_rst_n && s_valid && s_ready) begin
            seen_report = s_data[REPORT_W-1:0];
            reports_taken++;
            if (predict_partners(seen_report, due)) begin
                partner_q.push_back(due);
                reports_stored++;
            end
        end
    end

    // output transfers against the oldest expected partners
    always @(posedge i_clk) begin
        if (i_rst_n && m_valid && m_ready) begin
            got = m_data[PARTNERS_W-1:0];
            results_checked++;
            if (partner_q.size() == 0) begin
                $error("result with no report pending: head_partner %0d tail_partner %0d",
                       got.head_partner, got.tail_partner);
                mismatch_cnt++;
            end else begin
                want = partner_q.pop_front();
                if (got.head_partner !== want.head_partner) begin
                    $error("head_partner expected %0d got %0d",
                           want.head_partner, got.head_partner);
                    mismatch_cnt++;
                end
                if (got.tail_partner !== want.tail_partner) begin
                    $error("tail_partner expected %0d got %0d",
                           want.tail_partner, got.tail_partner);
                    mismatch_cnt++;
                end
                if (got.partner_changed !== want.partner_changed) begin
                    $error("partner_changed expected %0d got %0d",
                           want.partner_changed, got.partner_changed);
                    mismatch_cnt++;
                end
            end
        end
    end

    task automatic write_reg(input logic [CFG_ADDR_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        @(posedge i_clk);
        cfg_we   <= 1'b1;
        cfg_addr <= idx;
        cfg_data <= val;
        @(posedge i_clk);
        cfg_we <= 1'b0;
        case (idx)
            nlpf_pkg::CFG_OWN_ID:        own_id_cfg = int'(val);
            nlpf_pkg::CFG_OWN_HEAD_HEAD: own_links[LNK_HH] = val[0];
            nlpf_pkg::CFG_OWN_HEAD_TAIL: own_links[LNK_HT] = val[0];
            nlpf_pkg::CFG_OWN_TAIL_HEAD: own_links[LNK_TH] = val[0];
            nlpf_pkg::CFG_OWN_TAIL_TAIL: own_links[LNK_TT] = val[0];
            default: ;
        endcase
    endtask

    task automatic apply_settings(input int own, input logic [3:0] links);
        write_reg(nlpf_pkg::CFG_OWN_ID, own[ID_W-1:0]);
        write_reg(nlpf_pkg::CFG_OWN_HEAD_HEAD, {7'd0, links[LNK_HH]});
        write_reg(nlpf_pkg::CFG_OWN_HEAD_TAIL, {7'd0, links[LNK_HT]});
        write_reg(nlpf_pkg::CFG_OWN_TAIL_HEAD, {7'd0, links[LNK_TH]});
        write_reg(nlpf_pkg::CFG_OWN_TAIL_TAIL, {7'd0, links[LNK_TT]});
        settings_cnt++;
    endtask

    task automatic offer(input logic [ID_W-1:0] id, input logic [3:0] links);
        t_report rep;
        rep.sender_id = id;
        rep.hh        = links[LNK_HH];
        rep.ht        = links[LNK_HT];
        rep.th        = links[LNK_TH];
        rep.tt        = links[LNK_TT];
        report_q.push_back(rep);
    endtask

    // all reports taken, all results back, then let a dropped report finish too
    task automatic settle();
        do
            @(negedge i_clk);
        while (report_q.size() != 0 || s_valid || partner_q.size() != 0);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    // ids cluster around own id so nearest partners keep moving
    task automatic random_phase(input int own, input logic [3:0] links, input int flag_pct);
        int              stored;
        int              pick;
        logic [ID_W-1:0] id;
        logic [3:0]      f;
        settle();
        apply_settings(own, links);
        stored = 0;
        while (stored < RANDOM_STORED) begin
            pick = $urandom_range(0, 99);
            if (pick < 4)
                id = '0;
            else if (pick < 8)
                id = ID_W'(own);
            else if (pick < 55)
                id = ID_W'(own + int'($urandom_range(0, 20)) - 10);
            else
                id = ID_W'($urandom_range(1, 255));
            for (int b = 0; b < 4; b++)
                f[b] = ($urandom_range(0, 99) < flag_pct);
            offer(id, f);
            if (id != '0 && int'(id) != own)
                stored++;
        end
    endtask

    initial begin
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset settings: own id 1, no own links, so no partner ever
        offer(8'd1, 4'b1111);
        offer(8'd0, 4'b1111);
        offer(8'd2, 4'b0001);
        offer(8'd255, 4'b1111);
        offer(8'd128, 4'b0110);
        settle();

        // writes past the last register must not disturb anything
        for (int k = int'(nlpf_pkg::CFG_OWN_TAIL_TAIL) + 1; k < (1 << CFG_ADDR_W); k++)
            write_reg(CFG_ADDR_W'(k), 8'hFF);
        apply_settings(100, 4'b1111);

        // hand-picked: tie on distance, each link rule, own and zero ids, overwrite
        offer(8'd102, 4'b0001);
        offer(8'd98, 4'b0001);
        offer(8'd100, 4'b1111);
        offer(8'd0, 4'b1111);
        offer(8'd101, 4'b0100);
        offer(8'd99, 4'b0010);
        offer(8'd101, 4'b1000);
        offer(8'd99, 4'b0000);
        offer(8'd255, 4'b1111);
        offer(8'd1, 4'b1111);
        offer(8'd99, 4'b1111);
        offer(8'd99, 4'b1111);
        offer(8'd200, 4'b0001);
        offer(8'd170, 4'b1010);
        offer(8'd85, 4'b0101);
        offer(8'd99, 4'b0000);
        offer(8'd101, 4'b0000);

        random_phase(255, 4'b1111, 50);
        random_phase(1, 4'b1111, 20);
        random_phase(0, 4'b0101, 50);
        random_phase(128, 4'b0001, 30);
        random_phase($urandom_range(1, 254), 4'b0010, 50);
        random_phase($urandom_range(1, 254), 4'b1100, 10);
        random_phase($urandom_range(1, 254), 4'b0000, 50);
        random_phase($urandom_range(1, 254), 4'($urandom_range(0, 15)), 90);
        settle();

        $display("covered %0d reports (%0d stored, %0d dropped) over %0d register settings",
                 reports_taken, reports_stored, reports_taken - reports_stored, settings_cnt);
        $display("checked %0d results through %0d long output hold-offs",
                 results_checked, holds_done);
        if (mismatch_cnt == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

    // watchdog well beyond the slowest legal run
    initial begin
        #120ms;
        $error("timeout with %0d reports queued and %0d results outstanding",
               report_q.size(), partner_q.size());
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule
